FILE: hdl/chained_hash_map_engine_top_assert.svh
// assertion macros for the chained hash map engine
// concurrent checks compile out when SYNTHESIS is defined
`ifndef CHAINED_HASH_MAP_ENGINE_TOP_ASSERT_SVH
`define CHAINED_HASH_MAP_ENGINE_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define CHM_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define CHM_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CHM_ASSERT(lbl, clk, rst, prop, msg)
`define CHM_ASSERT_NR(lbl, clk, prop, msg)
`endif
`endif

FILE: hdl/chm_pkg.sv
// shared types, constants and helper functions of the chained hash map engine
// no dependencies
package chm_pkg;

  localparam int POOL_ENTRIES = 16;
  localparam int KEY_BITS     = 64;
  localparam int VALUE_BITS   = 64;

  localparam int POOL_SLOTS = POOL_ENTRIES + 1;
  localparam int IDX_W      = $clog2(POOL_SLOTS);
  localparam int CNT_W      = $clog2(POOL_SLOTS + 1);
  localparam int BKT_W      = $clog2(POOL_ENTRIES);
  localparam int BKT_N      = 1 << BKT_W;

  localparam int ADDR_W = 4;
  localparam logic [63:0] KEY_MASK = {64{1'b1}} >> (64 - KEY_BITS);
  localparam logic [31:0] JHASH_INIT = 32'hdeadbeef;

  typedef enum logic [1:0] {
    REG_ENTRY_CAP = 2'd0,
    REG_KEY_BYTES = 2'd1,
    REG_HASH_SEED = 2'd2,
    REG_UNUSED    = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    OP_LOOKUP = 2'd0,
    OP_UPDATE = 2'd1,
    OP_DELETE = 2'd2,
    OP_NEXT   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STS_OK        = 2'd0,
    STS_NOT_FOUND = 2'd1,
    STS_FULL      = 2'd2
  } status_t;

  typedef struct packed {
    logic [4:0]  entry_cap;
    logic [3:0]  key_bytes;
    logic [31:0] hash_seed;
  } cfg_t;

  typedef struct packed {
    logic             nv;
    logic [IDX_W-1:0] next;
  } link_t;

  typedef struct packed {
    logic [31:0]           hash;
    logic [KEY_BITS-1:0]   key;
    logic [VALUE_BITS-1:0] value;
  } elem_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    link_t            data;
  } link_wr_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    elem_t            data;
  } elem_wr_t;

  function automatic logic [31:0] rotl(input logic [31:0] x, input int unsigned r);
    return (x << r) | (x >> (32 - r));
  endfunction

  function automatic logic [3:0] key_len(input logic [3:0] kb);
    return (kb > 4'd8) ? 4'd8 : kb;
  endfunction

  function automatic logic [63:0] key_mask(input logic [3:0] kl);
    logic [63:0] m;
    if (kl >= 4'd8) begin
      m = {64{1'b1}};
    end else begin
      m = (64'd1 << {kl, 3'b000}) - 64'd1;
    end
    return m & KEY_MASK;
  endfunction

  // bucket mask: one less than the smallest power of two not below the entry cap, capped at the bucket array
  function automatic logic [BKT_W-1:0] bucket_mask(input logic [4:0] me);
    int unsigned n;
    n = 1;
    for (int i = 0; i < BKT_W; i++) begin
      if (n < 32'(me)) n = n << 1;
    end
    return BKT_W'(n - 1);
  endfunction

endpackage

FILE: hdl/chm_if.sv
// request and response channel interfaces of the chained hash map engine
// depends on chm_pkg for nothing; payload widths follow the field list
interface chm_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [63:0] key;
  logic [63:0] value;
  logic        has_key;
  modport source(output valid, operation, key, value, has_key, input ready);
  modport sink(input valid, operation, key, value, has_key, output ready);
endinterface

interface chm_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [63:0] value_out;
  logic [63:0] succ_key;
  modport source(output valid, status, value_out, succ_key, input ready);
  modport sink(input valid, status, value_out, succ_key, output ready);
endinterface

FILE: hdl/chm_regs.sv
// apb configuration registers: entry cap, key_bytes, hash_seed
// depends on chm_pkg
module chm_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [chm_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output chm_pkg::cfg_t               cfg
);
  import chm_pkg::*;

  reg_idx_t idx;
  logic     wr;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[3:2]);
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.entry_cap <= 5'd16;
      cfg.key_bytes <= 4'd8;
      cfg.hash_seed <= 32'd0;
    end else if (wr) begin
      unique case (idx)
        REG_ENTRY_CAP: cfg.entry_cap <= pwdata[4:0];
        REG_KEY_BYTES: cfg.key_bytes <= pwdata[3:0];
        REG_HASH_SEED: cfg.hash_seed <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_ENTRY_CAP: prdata = 32'(cfg.entry_cap);
      REG_KEY_BYTES: prdata = 32'(cfg.key_bytes);
      REG_HASH_SEED: prdata = cfg.hash_seed;
      default:       prdata = 32'd0;
    endcase
  end
endmodule

FILE: hdl/chm_hash.sv
// iterative jhash of a key of up to eight bytes, one mix step per cycle
// depends on chm_pkg
module chm_hash (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] key,
  input  logic [3:0]  len,
  input  logic [31:0] seed,
  output logic        done,
  output logic [31:0] hash
);
  import chm_pkg::*;

  logic [31:0] a, b, c, init;
  logic [2:0]  step;
  logic        busy, zlen;
  logic [31:0] init_next;

  assign init_next = JHASH_INIT + 32'(len) + seed;
  assign hash      = zlen ? init : c;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && step == 3'd6) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      init <= init_next;
      a    <= init_next + key[31:0];
      b    <= init_next + key[63:32];
      c    <= init_next;
      zlen <= (len == 4'd0);
      step <= 3'd0;
    end else if (busy) begin
      step <= step + 3'd1;
      unique case (step)
        3'd0: c <= (c ^ b) - rotl(b, 14);
        3'd1: a <= (a ^ c) - rotl(c, 11);
        3'd2: b <= (b ^ a) - rotl(a, 25);
        3'd3: c <= (c ^ b) - rotl(b, 16);
        3'd4: a <= (a ^ c) - rotl(c, 4);
        3'd5: b <= (b ^ a) - rotl(a, 14);
        3'd6: c <= (c ^ b) - rotl(b, 24);
        default: ;
      endcase
    end
  end
endmodule

FILE: hdl/chm_elem_ram.sv
// element pool memories: chain links and key/value/hash words
// one read port shared by both, registered read data; depends on chm_pkg
module chm_elem_ram (
  input  logic                      clk,
  input  logic                      rd_en,
  input  logic [chm_pkg::IDX_W-1:0] rd_addr,
  input  chm_pkg::link_wr_t         link_wr,
  input  chm_pkg::elem_wr_t         elem_wr,
  output chm_pkg::link_t            rd_link,
  output chm_pkg::elem_t            rd_elem
);
  import chm_pkg::*;

  link_t link_mem [POOL_SLOTS];
  elem_t elem_mem [POOL_SLOTS];

  always_ff @(posedge clk) begin
    if (link_wr.en) link_mem[link_wr.addr] <= link_wr.data;
    if (elem_wr.en) elem_mem[elem_wr.addr] <= elem_wr.data;
    if (rd_en) begin
      rd_link <= link_mem[rd_addr];
      rd_elem <= elem_mem[rd_addr];
    end
  end
endmodule

FILE: hdl/chained_hash_map_engine_top.sv
// chained hash map engine: one operation at a time, 1 result beat per request beat
// steps: accept, iterative hash, head lookup, one element read per chain element walked,
//   resolve/relink, output; get-next may add a bucket scan, then a successor key read
// throughput set by the iterative hash and the single element memory read port
// sync reset: chains empty, free stack full, live count zero, no beat pending
`include "chained_hash_map_engine_top_assert.svh"
module chained_hash_map_engine_top (
  input  logic                        clk,
  input  logic                        rst,
  chm_req_if.sink                     req,
  chm_rsp_if.source                   rsp,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [chm_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import chm_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE    = 10'b0000000001,
    S_HASH    = 10'b0000000010,
    S_HEAD    = 10'b0000000100,
    S_WALK    = 10'b0000001000,
    S_RESOLVE = 10'b0000010000,
    S_PUSH    = 10'b0000100000,
    S_SCAN    = 10'b0001000000,
    S_KEYRD   = 10'b0010000000,
    S_FIN     = 10'b0100000000,
    S_SPARE   = 10'b1000000000
  } state_t;

  cfg_t   cfg;
  state_t state;

  logic [BKT_W-1:0]  bmask;
  logic [3:0]        klen;
  logic [63:0]       km_cur;
  logic              accept;

  op_t                   op;
  logic [63:0]           k, km;
  logic [VALUE_BITS-1:0] v;
  logic                  hk;
  logic [31:0]           h;
  logic [BKT_W-1:0]      bkt;

  logic              hash_done;
  logic [31:0]       hash_val;

  logic [IDX_W-1:0]  head_idx [BKT_N];
  logic [BKT_N-1:0]  head_vld;
  logic [IDX_W-1:0]  free_stk [POOL_SLOTS];
  logic [CNT_W-1:0]  free_top, live_cnt, limit;

  logic [IDX_W-1:0]  cur, prev_idx, hit_idx, alloc_idx;
  logic              prev_v, hit;
  link_t             hit_link;
  elem_t             hit_elem;
  logic [BKT_W:0]    scan_i;
  logic [BKT_W-1:0]  scan_b;
  logic              scan_end, match, full;

  logic              rd_en;
  logic [IDX_W-1:0]  rd_addr;
  link_wr_t          link_wr;
  elem_wr_t          elem_wr;
  link_t             rd_link;
  elem_t             rd_elem;

  status_t           res_status;
  logic [63:0]       res_vout, res_nkey;
  logic              out_vld;
  logic [1:0]        out_status;
  logic [63:0]       out_vout, out_nkey;

  chm_regs u_regs (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  assign bmask  = bucket_mask(cfg.entry_cap);
  assign klen   = key_len(cfg.key_bytes);
  assign km_cur = key_mask(klen);
  assign limit  = (32'(cfg.entry_cap) < POOL_ENTRIES) ? CNT_W'(cfg.entry_cap)
                                                      : CNT_W'(POOL_ENTRIES);

  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;

  chm_hash u_hash (
    .clk, .rst,
    .start (accept),
    .key   (req.key & km_cur),
    .len   (klen),
    .seed  (cfg.hash_seed),
    .done  (hash_done),
    .hash  (hash_val)
  );

  chm_elem_ram u_ram (
    .clk, .rd_en, .rd_addr, .link_wr, .elem_wr, .rd_link, .rd_elem
  );

  assign bkt       = h[BKT_W-1:0] & bmask;
  assign scan_b    = scan_i[BKT_W-1:0];
  assign scan_end  = scan_i > {1'b0, bmask};
  assign match     = (rd_elem.hash == h) && (((64'(rd_elem.key) ^ k) & km) == 64'd0);
  assign full      = (live_cnt >= limit) || (free_top == '0);
  assign alloc_idx = free_stk[IDX_W'(free_top - 1'b1)];

  // memory requests for the current step
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = cur;
    link_wr = '0;
    elem_wr = '0;
    unique case (state)
      S_HEAD: begin
        if (head_vld[bkt]) begin
          rd_en   = 1'b1;
          rd_addr = head_idx[bkt];
        end
      end
      S_WALK: begin
        if (!match && rd_link.nv) begin
          rd_en   = 1'b1;
          rd_addr = rd_link.next;
        end
      end
      S_RESOLVE: begin
        unique case (op)
          OP_UPDATE: begin
            if (hit) begin
              if (prev_v) begin
                link_wr = '{en: 1'b1, addr: prev_idx, data: hit_link};
              end else begin
                elem_wr = '{en: 1'b1, addr: hit_idx,
                            data: '{hash: hit_elem.hash, key: hit_elem.key, value: v}};
              end
            end else if (!full) begin
              link_wr = '{en: 1'b1, addr: alloc_idx,
                          data: '{nv: head_vld[bkt], next: head_idx[bkt]}};
              elem_wr = '{en: 1'b1, addr: alloc_idx,
                          data: '{hash: h, key: k[KEY_BITS-1:0], value: v}};
            end
          end
          OP_DELETE: begin
            if (hit && prev_v) link_wr = '{en: 1'b1, addr: prev_idx, data: hit_link};
          end
          OP_NEXT: begin
            if (hk && hit && hit_link.nv) begin
              rd_en   = 1'b1;
              rd_addr = hit_link.next;
            end
          end
          default: ;
        endcase
      end
      S_PUSH: begin
        link_wr = '{en: 1'b1, addr: hit_idx,
                    data: '{nv: head_vld[bkt], next: head_idx[bkt]}};
        elem_wr = '{en: 1'b1, addr: hit_idx,
                    data: '{hash: hit_elem.hash, key: hit_elem.key, value: v}};
      end
      S_SCAN: begin
        if (!scan_end && head_vld[scan_b]) begin
          rd_en   = 1'b1;
          rd_addr = head_idx[scan_b];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      head_vld <= '0;
      free_top <= CNT_W'(POOL_SLOTS);
      live_cnt <= '0;
      out_vld  <= 1'b0;
      for (int i = 0; i < POOL_SLOTS; i++) free_stk[i] <= IDX_W'(i);
    end else begin
      // the output stage reloads the register itself
      if (out_vld && rsp.ready && state != S_FIN) out_vld <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            op    <= op_t'(req.operation);
            k     <= req.key & km_cur;
            km    <= km_cur;
            v     <= req.value[VALUE_BITS-1:0];
            hk    <= req.has_key;
            state <= S_HASH;
          end
        end
        S_HASH: begin
          if (hash_done) begin
            h     <= hash_val;
            state <= S_HEAD;
          end
        end
        S_HEAD: begin
          prev_v <= 1'b0;
          hit    <= 1'b0;
          if (head_vld[bkt]) begin
            cur   <= head_idx[bkt];
            state <= S_WALK;
          end else begin
            state <= S_RESOLVE;
          end
        end
        S_WALK: begin
          if (match) begin
            hit      <= 1'b1;
            hit_idx  <= cur;
            hit_link <= rd_link;
            hit_elem <= rd_elem;
            state    <= S_RESOLVE;
          end else if (rd_link.nv) begin
            prev_v   <= 1'b1;
            prev_idx <= cur;
            cur      <= rd_link.next;
          end else begin
            state <= S_RESOLVE;
          end
        end
        S_RESOLVE: begin
          unique case (op)
            OP_LOOKUP: begin
              res_status <= hit ? STS_OK : STS_NOT_FOUND;
              res_vout   <= hit ? 64'(hit_elem.value) : 64'd0;
              res_nkey   <= 64'd0;
              state      <= S_FIN;
            end
            OP_UPDATE: begin
              res_status <= (hit || !full) ? STS_OK : STS_FULL;
              res_vout   <= 64'd0;
              res_nkey   <= 64'd0;
              state      <= (hit && prev_v) ? S_PUSH : S_FIN;
              if (!hit && !full) begin
                free_top      <= free_top - 1'b1;
                live_cnt      <= live_cnt + 1'b1;
                head_idx[bkt] <= alloc_idx;
                head_vld[bkt] <= 1'b1;
              end
            end
            OP_DELETE: begin
              res_status <= hit ? STS_OK : STS_NOT_FOUND;
              res_vout   <= 64'd0;
              res_nkey   <= 64'd0;
              state      <= S_FIN;
              if (hit) begin
                if (!prev_v) begin
                  head_idx[bkt] <= hit_link.next;
                  head_vld[bkt] <= hit_link.nv;
                end
                if (32'(free_top) < POOL_SLOTS) begin
                  free_stk[IDX_W'(free_top)] <= hit_idx;
                  free_top <= free_top + 1'b1;
                end
                if (live_cnt != '0) live_cnt <= live_cnt - 1'b1;
              end
            end
            OP_NEXT: begin
              state  <= (hk && hit && hit_link.nv) ? S_KEYRD : S_SCAN;
              scan_i <= (hk && hit) ? {1'b0, bkt} + 1'b1 : '0;
            end
            default: ;
          endcase
        end
        S_PUSH: begin
          head_idx[bkt] <= hit_idx;
          head_vld[bkt] <= 1'b1;
          state         <= S_FIN;
        end
        S_SCAN: begin
          if (scan_end) begin
            res_status <= STS_NOT_FOUND;
            res_vout   <= 64'd0;
            res_nkey   <= 64'd0;
            state      <= S_FIN;
          end else if (head_vld[scan_b]) begin
            state <= S_KEYRD;
          end else begin
            scan_i <= scan_i + 1'b1;
          end
        end
        S_KEYRD: begin
          res_status <= STS_OK;
          res_vout   <= 64'd0;
          res_nkey   <= 64'(rd_elem.key) & km;
          state      <= S_FIN;
        end
        S_FIN: begin
          // wait for the output register to free up
          if (!out_vld || rsp.ready) begin
            out_vld    <= 1'b1;
            out_status <= res_status;
            out_vout   <= res_vout;
            out_nkey   <= res_nkey;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign rsp.valid     = out_vld;
  assign rsp.status    = out_status;
  assign rsp.value_out = out_vout;
  assign rsp.succ_key  = out_nkey;

  `CHM_ASSERT(a_pool_balance, clk, rst, (32'(free_top) + 32'(live_cnt) == POOL_SLOTS), "pool count mismatch")
  `CHM_ASSERT(a_walk_read, clk, rst, (state == S_WALK || state == S_KEYRD) |-> $past(rd_en), "element used without read")
  `CHM_ASSERT(a_accept_hash, clk, rst, accept |=> (state == S_HASH), "accepted beat not hashed")
  `CHM_ASSERT_NR(a_reset_idle, clk, $past(rst) |-> !rsp.valid, "response beat after reset")
endmodule

FILE: test/tb_chained_hash_map_engine_top.sv
// self-checking testbench for the chained hash map engine: random and directed map operations
// depends on chm_pkg, chm_if and the chained_hash_map_engine_top rtl
module tb_chained_hash_map_engine_top;
  import chm_pkg::*;

  typedef struct {
    op_t         op;
    logic [63:0] key;
    logic [63:0] value;
    logic        has_key;
  } map_op_t;

  typedef struct {
    logic [1:0]  status;
    logic [63:0] value_out;
    logic [63:0] succ_key;
  } map_rsp_t;

  localparam int LIMIT_CYCLES = 1000000;

  logic clk;
  logic rst;
  logic psel, penable, pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [31:0] pwdata, prdata;
  logic pready;

  chm_req_if req();
  chm_rsp_if rsp();

  chained_hash_map_engine_top dut (
    .clk(clk), .rst(rst), .req(req), .rsp(rsp),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // predictor copy of the map
  logic [4:0]  cur_max;
  logic [3:0]  cur_kb;
  logic [31:0] cur_seed;
  logic [4:0]  head_idx [BKT_N];
  logic        head_ok [BKT_N];
  logic [4:0]  nxt_idx [POOL_SLOTS];
  logic        nxt_ok [POOL_SLOTS];
  logic [63:0] ekey [POOL_SLOTS];
  logic [63:0] evalue [POOL_SLOTS];
  logic [31:0] ehash [POOL_SLOTS];
  logic [4:0]  free_idx [POOL_SLOTS];
  int          free_cnt;
  int          live;

  map_op_t  pending_ops[$];
  map_rsp_t expected_rsps[$];
  int errors = 0;
  int cycles = 0;

  // keys reused so that hits, replaces and deletes happen often
  logic [63:0] key_pool [8];

  function automatic logic [31:0] rol32(logic [31:0] x, int r);
    return (x << r) | (x >> (32 - r));
  endfunction

  function automatic logic [31:0] mix_hash(logic [63:0] k, int len);
    logic [31:0] a, b, c;
    a = 32'hdeadbeef + len + cur_seed;
    b = a;
    c = a;
    if (len == 0) return c;
    a += k[31:0];
    b += k[63:32];
    c ^= b; c -= rol32(b, 14);
    a ^= c; a -= rol32(c, 11);
    b ^= a; b -= rol32(a, 25);
    c ^= b; c -= rol32(b, 16);
    a ^= c; a -= rol32(c, 4);
    b ^= a; b -= rol32(a, 14);
    c ^= b; c -= rol32(b, 24);
    return c;
  endfunction

  function automatic map_rsp_t apply_map_op(map_op_t m);
    map_rsp_t r;
    int len, nb, bkt, lim, hit, prv, idx, steps, i;
    logic [63:0] km, k;
    logic [31:0] h;
    logic ok, done;
    len = (cur_kb > 8) ? 8 : cur_kb;
    km = (len >= 8) ? '1 : ((64'd1 << (8 * len)) - 1);
    k = m.key & km;
    nb = 1;
    while (nb < cur_max && nb < BKT_N) nb = nb << 1;
    h = mix_hash(k, len);
    bkt = h & (nb - 1);
    lim = (cur_max < POOL_ENTRIES) ? cur_max : POOL_ENTRIES;
    r.status = STS_NOT_FOUND;
    r.value_out = '0;
    r.succ_key = '0;
    hit = -1;
    prv = -1;
    ok = head_ok[bkt];
    idx = head_idx[bkt];
    steps = 0;
    while (ok && idx < POOL_SLOTS && steps < POOL_SLOTS && hit < 0) begin
      if (ehash[idx] == h && ((ekey[idx] ^ k) & km) == 0) begin
        hit = idx;
      end else begin
        prv = idx;
        ok = nxt_ok[idx];
        idx = nxt_idx[idx];
        steps++;
      end
    end
    case (m.op)
      OP_LOOKUP: begin
        if (hit >= 0) begin
          r.status = STS_OK;
          r.value_out = evalue[hit];
        end
      end
      OP_UPDATE: begin
        if (hit >= 0) begin
          if (prv < 0) begin
            head_idx[bkt] = nxt_idx[hit]; head_ok[bkt] = nxt_ok[hit];
          end else begin
            nxt_idx[prv] = nxt_idx[hit]; nxt_ok[prv] = nxt_ok[hit];
          end
          evalue[hit] = m.value;
          nxt_idx[hit] = head_idx[bkt]; nxt_ok[hit] = head_ok[bkt];
          head_idx[bkt] = hit; head_ok[bkt] = 1'b1;
          r.status = STS_OK;
        end else if (live >= lim || free_cnt == 0) begin
          r.status = STS_FULL;
        end else begin
          free_cnt--;
          idx = free_idx[free_cnt];
          ekey[idx] = k; evalue[idx] = m.value; ehash[idx] = h;
          nxt_idx[idx] = head_idx[bkt]; nxt_ok[idx] = head_ok[bkt];
          head_idx[bkt] = idx; head_ok[bkt] = 1'b1;
          live++;
          r.status = STS_OK;
        end
      end
      OP_DELETE: begin
        if (hit >= 0) begin
          if (prv < 0) begin
            head_idx[bkt] = nxt_idx[hit]; head_ok[bkt] = nxt_ok[hit];
          end else begin
            nxt_idx[prv] = nxt_idx[hit]; nxt_ok[prv] = nxt_ok[hit];
          end
          if (free_cnt < POOL_SLOTS) begin
            free_idx[free_cnt] = hit; free_cnt++;
          end
          if (live > 0) live--;
          r.status = STS_OK;
        end
      end
      default: begin
        i = 0;
        done = 1'b0;
        if (m.has_key && hit >= 0) begin
          if (nxt_ok[hit] && nxt_idx[hit] < POOL_SLOTS) begin
            r.succ_key = ekey[nxt_idx[hit]] & km;
            r.status = STS_OK;
            done = 1'b1;
          end else begin
            i = bkt + 1;
          end
        end
        for (; !done && i < nb; i++) begin
          if (head_ok[i] && head_idx[i] < POOL_SLOTS) begin
            r.succ_key = ekey[head_idx[i]] & km;
            r.status = STS_OK;
            done = 1'b1;
          end
        end
      end
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h expected %h at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // request driver
  int req_wait;
  always @(posedge clk) begin
    if (rst) begin
      req.valid <= 1'b0;
      req.operation <= OP_LOOKUP;
      req.key <= '0;
      req.value <= '0;
      req.has_key <= 1'b0;
      req_wait <= $urandom_range(0, 4);
      for (int i = 0; i < BKT_N; i++) begin
        head_idx[i] = '0; head_ok[i] = 1'b0;
      end
      for (int i = 0; i < POOL_SLOTS; i++) begin
        nxt_idx[i] = '0; nxt_ok[i] = 1'b0; ekey[i] = '0; evalue[i] = '0; ehash[i] = '0;
        free_idx[i] = 5'(i);
      end
      free_cnt = POOL_SLOTS;
      live = 0;
    end else if (req.valid && !req.ready) begin
      // hold beat
    end else if (req.valid) begin
      expected_rsps.push_back(apply_map_op(pending_ops.pop_front()));
      req_wait <= $urandom_range(0, 4);
      req.valid <= 1'b0;
    end else if (req_wait == 0 && pending_ops.size() > 0) begin
      req.valid <= 1'b1;
      req.operation <= pending_ops[0].op;
      req.key <= pending_ops[0].key;
      req.value <= pending_ops[0].value;
      req.has_key <= pending_ops[0].has_key;
    end else if (req_wait > 0) begin
      req_wait <= req_wait - 1;
    end
  end

  // response monitor with random stalls
  int rsp_wait;
  always @(posedge clk) begin
    map_rsp_t want;
    if (rst) begin
      rsp.ready <= 1'b0;
      rsp_wait <= 0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (expected_rsps.size() == 0) begin
          report_mismatch("unexpected beat", 64'(rsp.status), 64'd0);
        end else begin
          want = expected_rsps.pop_front();
          if (rsp.status !== want.status)
            report_mismatch("status", 64'(rsp.status), 64'(want.status));
          if (rsp.value_out !== want.value_out)
            report_mismatch("value_out", rsp.value_out, want.value_out);
          if (rsp.succ_key !== want.succ_key)
            report_mismatch("succ_key", rsp.succ_key, want.succ_key);
        end
        rsp_wait <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
        rsp.ready <= 1'b0;
      end else if (rsp_wait > 0) begin
        rsp_wait <= rsp_wait - 1;
        rsp.ready <= 1'b0;
      end else begin
        rsp.ready <= 1'b1;
      end
    end
  end

  task automatic write_reg(reg_idx_t ri, logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= ADDR_W'(4 * ri); pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (ri)
      REG_ENTRY_CAP: cur_max = val[4:0];
      REG_KEY_BYTES: cur_kb = val[3:0];
      REG_HASH_SEED: cur_seed = val;
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    do @(posedge clk); while (pending_ops.size() != 0 || req.valid || expected_rsps.size() != 0);
    repeat (40) @(posedge clk);
  endtask

  task automatic queue_op(op_t op, logic [63:0] key, logic [63:0] value, logic has_key);
    map_op_t m;
    m.op = op; m.key = key; m.value = value; m.has_key = has_key;
    pending_ops.push_back(m);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  task automatic queue_random(int count);
    map_op_t m;
    for (int n = 0; n < count; n++) begin
      m.op = op_t'($urandom_range(0, 3));
      m.key = ($urandom_range(0, 9) < 8) ? key_pool[$urandom_range(0, 7)] : rand64();
      m.value = rand64();
      m.has_key = ($urandom_range(0, 3) != 0);
      // bias toward inserts so the table fills up
      if ($urandom_range(0, 4) == 0) m.op = OP_UPDATE;
      pending_ops.push_back(m);
    end
  endtask

  initial begin
    rst = 1'b1;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    cur_max = 5'd16; cur_kb = 4'd8; cur_seed = '0;
    for (int i = 0; i < 8; i++) key_pool[i] = rand64();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    repeat (40) @(posedge clk);

    // directed: empty table, extremes, all ops, then a run of inserts that stops short of a full table
    queue_op(OP_LOOKUP, '0, '0, 1'b0);
    queue_op(OP_NEXT, '0, '0, 1'b0);
    queue_op(OP_DELETE, '1, '0, 1'b0);
    queue_op(OP_UPDATE, '0, '1, 1'b0);
    queue_op(OP_UPDATE, '1, 64'h5555_aaaa_5555_aaaa, 1'b0);
    queue_op(OP_LOOKUP, '1, '0, 1'b0);
    queue_op(OP_UPDATE, '1, 64'h1234, 1'b0);
    queue_op(OP_NEXT, '0, '0, 1'b0);
    queue_op(OP_NEXT, '1, '0, 1'b1);
    queue_op(OP_NEXT, 64'h77, '0, 1'b1);
    queue_op(OP_DELETE, '0, '0, 1'b0);
    queue_op(OP_LOOKUP, '0, '0, 1'b0);
    for (int i = 0; i < 13; i++) queue_op(OP_UPDATE, 64'(i * 3 + 1), 64'(i), 1'b0);
    wait_drained();

    // settings sweep including extremes and the out-of-range cases
    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        0: begin write_reg(REG_ENTRY_CAP, 1); write_reg(REG_KEY_BYTES, 1); end
        1: begin write_reg(REG_ENTRY_CAP, 0); write_reg(REG_KEY_BYTES, 0); end
        2: begin write_reg(REG_ENTRY_CAP, 31); write_reg(REG_KEY_BYTES, 15); end
        3: begin write_reg(REG_ENTRY_CAP, 16); write_reg(REG_KEY_BYTES, 8); end
        4: write_reg(REG_HASH_SEED, 32'hffff_ffff);
        5: begin write_reg(REG_ENTRY_CAP, 5); write_reg(REG_KEY_BYTES, 3); end
        6: write_reg(REG_HASH_SEED, 0);
        default: begin
          write_reg(REG_ENTRY_CAP, $urandom_range(0, 31));
          write_reg(REG_KEY_BYTES, $urandom_range(0, 15));
          write_reg(REG_HASH_SEED, $urandom());
        end
      endcase
      for (int i = 0; i < 8; i++) key_pool[i] = rand64();
      queue_random(140);
      wait_drained();
    end
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+hdl
hdl/chm_pkg.sv
hdl/chm_if.sv
hdl/chm_regs.sv
hdl/chm_hash.sv
hdl/chm_elem_ram.sv
hdl/chained_hash_map_engine_top.sv
test/tb_chained_hash_map_engine_top.sv
